### design/multi_input_toggle_watchdog_macros.svh
// Assertion helpers shared by the watchdog modules.
// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef MULTI_INPUT_TOGGLE_WATCHDOG_MACROS_SVH
`define MULTI_INPUT_TOGGLE_WATCHDOG_MACROS_SVH

`define MITW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define MITW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/mitw_pkg.sv
`timescale 1ns / 1ps

package mitw_pkg;

  localparam int MAX_WATCH         = 4;
  localparam int NUM_WATCHED_DEF   = 4;
  localparam int COUNT_WIDTH_DEF   = 40;
  localparam int TIMEOUT_W         = 40;
  localparam int BITS_W            = 4;
  localparam int PERIOD_W          = 30;
  localparam int CFG_INDEX_W       = 3;
  localparam int IN_TDATA_W        = 40;
  localparam int OUT_TDATA_W       = 8;

  localparam int BITS_LSB          = 0;
  localparam int ENABLE_BIT        = BITS_LSB + BITS_W;
  localparam int PERIOD_LSB        = ENABLE_BIT + 1;

  localparam logic KIND_TICK       = 1'b0;
  localparam logic KIND_ARM        = 1'b1;

  typedef struct packed {
    logic tick;
    logic rearm;
  } lane_ctrl_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [TIMEOUT_W-1:0]   data;
  } cfg_wr_t;

endpackage

### design/mitw_lane.sv
`timescale 1ns / 1ps

module mitw_lane #(
  parameter int COUNT_WIDTH = 40,
  parameter int LANE_ID     = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mitw_pkg::lane_ctrl_t              ctrl,
  input  mitw_pkg::cfg_wr_t                 cfg,
  input  logic                              bit_in,
  input  logic [mitw_pkg::PERIOD_W-1:0]     period,
  output logic                              fault
);
  import mitw_pkg::*;

  logic [TIMEOUT_W-1:0]               timeout_r;
  logic [COUNT_WIDTH-1:0]             remaining_r, remaining_nxt;
  logic                               prev_bit_r, prev_bit_nxt;
  logic [TIMEOUT_W+COUNT_WIDTH-1:0]   reload_ext;
  logic [PERIOD_W+COUNT_WIDTH-1:0]    period_wide;
  logic [COUNT_WIDTH-1:0]             reload;
  logic [COUNT_WIDTH-1:0]             period_ext;
  logic                               toggled;
  logic                               under;

  assign reload_ext  = {{COUNT_WIDTH{1'b0}}, timeout_r};
  assign reload      = reload_ext[COUNT_WIDTH-1:0];
  assign period_wide = {{COUNT_WIDTH{1'b0}}, period};
  assign period_ext  = period_wide[COUNT_WIDTH-1:0];
  assign toggled     = bit_in != prev_bit_r;
  assign under       = remaining_r < period_ext;
  assign fault       = ctrl.tick && !toggled && under;

  always_comb begin
    remaining_nxt = remaining_r;
    prev_bit_nxt  = prev_bit_r;
    if (ctrl.rearm) begin
      remaining_nxt = reload;
    end else if (ctrl.tick) begin
      prev_bit_nxt = bit_in;
      if (toggled) begin
        remaining_nxt = reload;
      end else if (under) begin
        remaining_nxt = '0;
      end else begin
        remaining_nxt = remaining_r - period_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= '0;
      remaining_r <= '0;
      prev_bit_r  <= 1'b0;
    end else begin
      if (cfg.we && cfg.index == CFG_INDEX_W'(LANE_ID)) begin
        timeout_r <= cfg.data;
      end
      remaining_r <= remaining_nxt;
      prev_bit_r  <= prev_bit_nxt;
    end
  end

endmodule

### design/mitw_merge.sv
`timescale 1ns / 1ps
`include "multi_input_toggle_watchdog_macros.svh"

module mitw_merge #(
  parameter int NUM_WATCHED = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       kind,
  input  logic                       enable_level,
  input  logic [NUM_WATCHED-1:0]     lane_fault,
  output mitw_pkg::lane_ctrl_t       ctrl,
  output logic                       ready,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       res_ok
);
  import mitw_pkg::*;

  logic       ok_flag_r, ok_flag_nxt;
  logic       prev_en_r, prev_en_nxt;
  logic [1:0] count_r, count_nxt;
  logic       slot0_r, slot0_nxt;
  logic       slot1_r, slot1_nxt;
  logic       pop;

  assign ctrl.tick  = push && kind == KIND_TICK && enable_level && ok_flag_r;
  assign ctrl.rearm = push && kind == KIND_ARM && !ok_flag_r && enable_level && !prev_en_r;

  assign ready     = count_r != 2'd2;
  assign res_valid = count_r != 2'd0;
  assign res_ok    = slot0_r;
  assign pop       = res_valid && res_ready;

  always_comb begin
    ok_flag_nxt = ok_flag_r;
    prev_en_nxt = prev_en_r;
    if (ctrl.tick) begin
      ok_flag_nxt = !(|lane_fault);
    end else if (ctrl.rearm) begin
      ok_flag_nxt = 1'b1;
    end
    if (push && kind == KIND_ARM) begin
      prev_en_nxt = enable_level;
    end
  end

  always_comb begin
    count_nxt = count_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          slot0_nxt = ok_flag_nxt;
        end else begin
          slot1_nxt = ok_flag_nxt;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        slot0_nxt = ok_flag_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_flag_r <= 1'b0;
      prev_en_r <= 1'b0;
      count_r   <= 2'd0;
    end else begin
      ok_flag_r <= ok_flag_nxt;
      prev_en_r <= prev_en_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  `MITW_ASSERT(a_tick_rearm_excl, !(ctrl.tick && ctrl.rearm), "tick and rearm at once")
  `MITW_ASSERT_NEXT(a_rearm_sets_ok, ctrl.rearm, ok_flag_r, "rearm did not set ok")
  `MITW_ASSERT_NEXT(a_fault_clears_ok, ctrl.tick && (|lane_fault), !ok_flag_r,
                    "lane fault did not clear ok")
  `MITW_ASSERT_NEXT(a_no_push_when_full, count_r == 2'd2 && !pop, !push,
                    "beat taken while result buffer full")
  `MITW_ASSERT(a_ok_rise_by_rearm, $rose(ok_flag_r) |-> $past(ctrl.rearm),
               "ok rose without rearm")

endmodule

### design/multi_input_toggle_watchdog.sv
`timescale 1ns / 1ps
// The result of an input beat is registered into the result buffer before it is shown on the output.
// Throughput: one beat per cycle (lane compare and subtract) while the buffer has room.
// A two-entry result buffer lets input beats keep coming while a result waits.
// Reset (synchronous, active low) clears timeouts, counters, ok, enable history and buffer.
module multi_input_toggle_watchdog #(
  parameter int NUM_WATCHED = mitw_pkg::NUM_WATCHED_DEF,
  parameter int COUNT_WIDTH = mitw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // watched_bits[3:0], enable_level[4], period_ns[34:5], zero fill above
  input  logic [mitw_pkg::IN_TDATA_W-1:0]      in_tdata,
  // kind[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // ok[0], zero fill above
  output logic [mitw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mitw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mitw_pkg::TIMEOUT_W-1:0]       cfg_data
);
  import mitw_pkg::*;

  lane_ctrl_t             ctrl;
  cfg_wr_t                cfg;
  logic                   push;
  logic                   ready;
  logic                   res_ok;
  logic [NUM_WATCHED-1:0] lane_fault;
  logic [BITS_W-1:0]      watched_bits;
  logic [PERIOD_W-1:0]    period_ns;

  assign watched_bits = in_tdata[BITS_LSB +: BITS_W];
  assign period_ns    = in_tdata[PERIOD_LSB +: PERIOD_W];
  assign in_tready    = ready;
  assign push         = in_tvalid && ready;
  assign cfg_ready    = 1'b1;
  assign cfg.we       = cfg_valid;
  assign cfg.index    = cfg_index;
  assign cfg.data     = cfg_data;
  assign out_tdata    = {{(OUT_TDATA_W-1){1'b0}}, res_ok};

  for (genvar g = 0; g < NUM_WATCHED; g++) begin : g_lane
    mitw_lane #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .LANE_ID    (g)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .cfg   (cfg),
      .bit_in(watched_bits[g]),
      .period(period_ns),
      .fault (lane_fault[g])
    );
  end

  mitw_merge #(
    .NUM_WATCHED(NUM_WATCHED)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .kind        (in_tuser),
    .enable_level(in_tdata[ENABLE_BIT]),
    .lane_fault  (lane_fault),
    .ctrl        (ctrl),
    .ready       (ready),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_ok      (res_ok)
  );

endmodule

### tb/sv/multi_input_toggle_watchdog_checker.sv
`timescale 1ns / 1ps

module watchdog_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [mitw_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [mitw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mitw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mitw_pkg::TIMEOUT_W-1:0]   cfg_data,
  output int                               mismatches,
  output int                               pending
);
  import mitw_pkg::*;

  logic [TIMEOUT_W-1:0]       timeout_q   [MAX_WATCH];
  logic [COUNT_WIDTH_DEF-1:0] remaining_q [MAX_WATCH];
  logic [MAX_WATCH-1:0]       last_bits_q;
  logic                       ok_q;
  logic                       last_en_q;
  logic                       ok_expected_q [$];
  logic                       ok_want;
  int                         mismatch_count = 0;

  function automatic logic advance_watchdog(input logic kind, input logic [BITS_W-1:0] bits,
                                            input logic en, input logic [PERIOD_W-1:0] period);
    bit fault;
    fault = 1'b0;
    if (kind == KIND_TICK) begin
      if (en && ok_q) begin
        for (int i = 0; i < NUM_WATCHED_DEF; i++) begin
          if (bits[i] != last_bits_q[i]) begin
            remaining_q[i] = timeout_q[i];
          end else if (remaining_q[i] < period) begin
            fault = 1'b1;
            remaining_q[i] = '0;
          end else begin
            remaining_q[i] = remaining_q[i] - period;
          end
          last_bits_q[i] = bits[i];
        end
        if (fault) ok_q = 1'b0;
      end
    end else begin
      if (!ok_q && en && !last_en_q) begin
        for (int i = 0; i < NUM_WATCHED_DEF; i++) remaining_q[i] = timeout_q[i];
        ok_q = 1'b1;
      end
      last_en_q = en;
    end
    return ok_q;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WATCH; i++) begin
        timeout_q[i] = '0;
        remaining_q[i] = '0;
      end
      last_bits_q = '0;
      ok_q = 1'b0;
      last_en_q = 1'b0;
      ok_expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < MAX_WATCH) timeout_q[cfg_index[1:0]] = cfg_data;
      if (out_tvalid && out_tready) begin
        if (ok_expected_q.size() == 0) begin
          $error("ok: expected none, actual %0d", out_tdata[0]);
          mismatch_count++;
        end else begin
          ok_want = ok_expected_q.pop_front();
          if (out_tdata[0] !== ok_want) begin
            $error("ok: expected %0d, actual %0d", ok_want, out_tdata[0]);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        ok_expected_q.push_back(advance_watchdog(in_tuser, in_tdata[BITS_LSB +: BITS_W],
                                                 in_tdata[ENABLE_BIT],
                                                 in_tdata[PERIOD_LSB +: PERIOD_W]));
      end
      pending <= ok_expected_q.size();
    end
    mismatches <= mismatch_count;
  end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mitw_pkg::*;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX  = '1;
  localparam int                   PERIOD_MAX   = 999999999;
  localparam int                   RANDOM_ITEMS = 550;
  localparam int                   PHASE_ITEMS  = 55;
  localparam int                   INDEX_TOP    = (1 << CFG_INDEX_W) - 1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [TIMEOUT_W-1:0]   cfg_data;
  int                     mismatches;
  int                     pending;

  bit                     gap_free;
  int                     stall_left = 0;
  int                     items_sent;
  logic [BITS_W-1:0]      level;
  logic [TIMEOUT_W-1:0]   timeout_plan [MAX_WATCH];

  multi_input_toggle_watchdog uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  watchdog_checker ok_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("multi_input_toggle_watchdog: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PERIOD_W-1:0] draw_period(input int pscale);
    return PERIOD_W'($urandom_range(1, pscale));
  endfunction

  function automatic logic [TIMEOUT_W-1:0] draw_timeout(input int pscale);
    int               pick;
    longint unsigned  raw;
    longint unsigned  span;
    pick = $urandom_range(0, 9);
    raw = {$urandom, $urandom};
    span = longint'(pscale) * 12;
    if (pick == 0) return '0;
    if (pick == 1) return TIMEOUT_MAX;
    if (pick == 2) return raw[TIMEOUT_W-1:0];
    raw = (raw % span) + 1;
    return raw[TIMEOUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!gap_free && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  task automatic send_item(input logic kind, input logic [BITS_W-1:0] bits, input logic en,
                           input logic [PERIOD_W-1:0] period);
    int                    gap;
    logic [IN_TDATA_W-1:0] beat;
    gap = (!gap_free && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat = '0;
    beat[BITS_LSB +: BITS_W] = bits;
    beat[ENABLE_BIT] = en;
    beat[PERIOD_LSB +: PERIOD_W] = period;
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    in_tuser <= kind;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TIMEOUT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_timeouts(input bit with_stray);
    settle();
    for (int i = 0; i < MAX_WATCH; i++) write_reg(CFG_INDEX_W'(i), timeout_plan[i]);
    if (with_stray) begin
      write_reg(CFG_INDEX_W'($urandom_range(MAX_WATCH, INDEX_TOP)),
                TIMEOUT_W'({$urandom, $urandom}));
    end
    cfg_valid <= 1'b0;
  endtask

  // Arm, usually from a low enable, then run ticks with the enable mostly held high.
  task automatic run_arm_burst(input int pscale);
    int                len;
    int                pct;
    logic [BITS_W-1:0] flip;
    if ($urandom_range(0, 3) != 0) send_item(KIND_ARM, level, 1'b0, draw_period(pscale));
    send_item(KIND_ARM, level, 1'b1, draw_period(pscale));
    len = $urandom_range(3, 15);
    pct = $urandom_range(10, 70);
    repeat (len) begin
      for (int b = 0; b < BITS_W; b++) flip[b] = ($urandom_range(0, 99) < pct);
      level = level ^ flip;
      send_item(KIND_TICK, level, $urandom_range(0, 9) != 0, draw_period(pscale));
    end
  endtask

  initial begin
    int pscale;
    int phase;
    int target;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_TICK;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_free = 1'b0;
    items_sent = 0;
    level = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    timeout_plan[0] = 30;
    timeout_plan[1] = 0;
    timeout_plan[2] = TIMEOUT_MAX;
    timeout_plan[3] = 20;
    load_timeouts(1'b1);

    send_item(KIND_TICK, 4'hF, 1'b1, 10);
    send_item(KIND_ARM,  4'h0, 1'b0, 10);
    send_item(KIND_ARM,  4'h0, 1'b1, 10);
    send_item(KIND_TICK, 4'h2, 1'b0, 10);
    send_item(KIND_TICK, 4'h2, 1'b1, 10);
    send_item(KIND_TICK, 4'h0, 1'b1, 10);
    send_item(KIND_TICK, 4'h3, 1'b1, 10);
    send_item(KIND_TICK, 4'hB, 1'b1, 10);
    send_item(KIND_TICK, 4'hB, 1'b1, 0);
    send_item(KIND_TICK, 4'hB, 1'b1, 1);
    send_item(KIND_ARM,  4'h0, 1'b1, 1);
    send_item(KIND_TICK, 4'h0, 1'b1, 1);
    send_item(KIND_ARM,  4'h5, 1'b0, PERIOD_W'(PERIOD_MAX));
    send_item(KIND_ARM,  4'h5, 1'b1, PERIOD_W'(PERIOD_MAX));
    send_item(KIND_ARM,  4'h5, 1'b0, PERIOD_W'(PERIOD_MAX));
    send_item(KIND_ARM,  4'h5, 1'b1, PERIOD_W'(PERIOD_MAX));
    send_item(KIND_TICK, 4'h4, 1'b1, PERIOD_W'(PERIOD_MAX));
    send_item(KIND_ARM,  4'hA, 1'b0, 1);
    send_item(KIND_ARM,  4'hA, 1'b1, 1);
    send_item(KIND_TICK, 4'h5, 1'b1, PERIOD_W'(PERIOD_MAX));

    timeout_plan[0] = TIMEOUT_MAX;
    timeout_plan[1] = 25;
    timeout_plan[2] = 0;
    timeout_plan[3] = 40;
    load_timeouts(1'b0);
    level = 4'h5;
    send_item(KIND_ARM,  level, 1'b0, 1);
    send_item(KIND_ARM,  level, 1'b1, 1);
    send_item(KIND_TICK, 4'h1, 1'b1, 20);
    send_item(KIND_TICK, 4'h5, 1'b1, 20);
    level = 4'h5;

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: pscale = 16;
        1: pscale = 5000;
        default: pscale = PERIOD_MAX;
      endcase
      for (int i = 0; i < MAX_WATCH; i++) timeout_plan[i] = draw_timeout(pscale);
      load_timeouts($urandom_range(0, 2) == 0);
      gap_free <= (phase % 4 == 3);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 85) begin
          run_arm_burst(pscale);
        end else begin
          send_item(1'($urandom_range(0, 1)), BITS_W'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)), PERIOD_W'($urandom_range(1, PERIOD_MAX)));
        end
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("multi_input_toggle_watchdog: match");
    end else begin
      $display("multi_input_toggle_watchdog: mismatch");
    end
    $finish;
  end
endmodule
